[rtl/double_ended_queue_defines.svh]
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Clocked assertion helpers used by the queue's checker.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Property that must hold at every rising edge outside reset.
`define DEQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a rising edge outside reset.
`define DEQ_NEVER(label, clk, rst_n, expr, msg) \
    `DEQ_ASSERT(label, clk, rst_n, (!(expr)), msg)

`endif

[rtl/deq_pkg.sv]
// ----------------------------------------------------------------------------
// Double-ended queue package
// Transaction types, action and status codes, and shared constants.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DATA_W    = 32;
    localparam int CNT_OUT_W = 5;

    localparam logic signed [DATA_W-1:0] NONE_VALUE = 32'shFFFF_FFFF;

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_REAR  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_REAR   = 3'd3,
        ACT_REPORT     = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_LOAD = 1'b1
    } t_state;

    typedef struct packed {
        logic [2:0]               action;
        logic signed [DATA_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] rear_value;
        logic [CNT_OUT_W-1:0]     entry_count;
        logic                     is_empty;
        logic                     is_full;
        t_status                  status;
    } t_out;

    typedef struct packed {
        logic    fwd_front;
        logic    fwd_rear;
        t_status status;
    } t_res_info;

endpackage

[rtl/deq_mem.sv]
// ----------------------------------------------------------------------------
// Double-ended queue store
// One write port and two registered read ports over DEPTH entries.
// ----------------------------------------------------------------------------
module deq_mem #(
    parameter int DEPTH = 16,
    parameter int IW    = 4
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [IW-1:0]              i_wr_addr,
    input  logic [deq_pkg::DATA_W-1:0] i_wr_data,
    input  logic                       i_rd_en,
    input  logic [IW-1:0]              i_rd_addr_a,
    input  logic [IW-1:0]              i_rd_addr_b,
    output logic [deq_pkg::DATA_W-1:0] o_rd_data_a,
    output logic [deq_pkg::DATA_W-1:0] o_rd_data_b
);
    import deq_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data_a <= r_mem[i_rd_addr_a];
            o_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

endmodule

[rtl/deq_ctrl.sv]
// ----------------------------------------------------------------------------
// Double-ended queue control
// Head and count pointers, store write and read addressing, sequencing.
// ----------------------------------------------------------------------------
module deq_ctrl #(
    parameter int DEPTH = 16,
    parameter int IW    = 4,
    parameter int CW    = 5
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  deq_pkg::t_in               i_in_data,
    input  logic                       i_out_free,
    output logic                       o_load,
    output logic                       o_wr_en,
    output logic [IW-1:0]              o_wr_addr,
    output logic [deq_pkg::DATA_W-1:0] o_wr_data,
    output logic                       o_rd_en,
    output logic [IW-1:0]              o_rd_addr_a,
    output logic [IW-1:0]              o_rd_addr_b,
    output logic [CW-1:0]              o_count,
    output deq_pkg::t_res_info         o_info,
    output logic [deq_pkg::DATA_W-1:0] o_push_value
);
    import deq_pkg::*;

    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [IW:0]   WRAP     = (IW+1)'(DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

    function automatic logic [IW-1:0] wrap_idx(input logic [IW:0] sum);
        logic [IW:0] adj;
        adj = (sum >= WRAP) ? (sum - WRAP) : sum;
        return adj[IW-1:0];
    endfunction

    t_state            r_state, n_state;
    logic [IW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_count, n_count;
    t_res_info         r_info, n_info;
    logic [DATA_W-1:0] r_value;

    logic          accept, full, empty;
    logic          is_push_f, is_push_r, is_pop_f, is_pop_r;
    logic          push_ok;
    logic [IW-1:0] head_dec, head_inc, tail_idx;
    logic [IW:0]   rear_sum;

    always_comb begin
        accept    = i_in_valid && (r_state == S_IDLE);
        full      = (r_count == FULL_CNT);
        empty     = (r_count == '0);
        is_push_f = (i_in_data.action == ACT_PUSH_FRONT);
        is_push_r = (i_in_data.action == ACT_PUSH_REAR);
        is_pop_f  = (i_in_data.action == ACT_POP_FRONT);
        is_pop_r  = (i_in_data.action == ACT_POP_REAR);
        push_ok   = (is_push_f || is_push_r) && !full;
        head_dec  = (r_head == '0) ? LAST_IDX : (r_head - 1'b1);
        head_inc  = wrap_idx({1'b0, r_head} + (IW+1)'(1));
        tail_idx  = wrap_idx({1'b0, r_head} + (IW+1)'(r_count));

        n_head           = r_head;
        n_count          = r_count;
        n_info.fwd_front = push_ok && (is_push_f || empty);
        n_info.fwd_rear  = push_ok && (is_push_r || empty);
        n_info.status    = ST_DONE;
        o_wr_en          = 1'b0;
        o_wr_addr        = tail_idx;

        if (is_push_f || is_push_r) begin
            if (full) begin
                n_info.status = ST_FULL;
            end else if (is_push_f) begin
                n_head    = head_dec;
                n_count   = r_count + 1'b1;
                o_wr_en   = accept;
                o_wr_addr = head_dec;
            end else begin
                n_count   = r_count + 1'b1;
                o_wr_en   = accept;
            end
        end else if (is_pop_f || is_pop_r) begin
            if (empty) begin
                n_info.status = ST_EMPTY;
            end else begin
                if (is_pop_f) begin
                    n_head = head_inc;
                end
                n_count = r_count - 1'b1;
            end
        end

        rear_sum    = {1'b0, n_head} + (IW+1)'(n_count) - (IW+1)'(1);
        o_rd_en     = accept;
        o_rd_addr_a = n_head;
        o_rd_addr_b = (n_count == '0) ? '0 : wrap_idx(rear_sum);
        o_wr_data   = i_in_data.value;
    end

    always_comb begin
        n_state = r_state;
        o_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_load = i_out_free;
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_info  <= n_info;
            r_value <= i_in_data.value;
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_count      = r_count;
    assign o_info       = r_info;
    assign o_push_value = r_value;

endmodule

[rtl/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// Double-ended queue
// Signed 32-bit deque in a circular store with push, pop and report actions.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | i_in_valid / o_in_stall  | i_in_data  (t_in)
//  out     | output    | o_out_valid / i_out_stall| o_out_data (t_out)
//
//  Each transaction first updates head and count, writes the store and reads
//  the new front and rear entries, then forms the result.
//  The store has a single write port and registered read ports.
//  A new transaction is taken as soon as the result enters the output register.
//  Reset clears state, head, count and output valid; the store needs no clearing pass.
//  A stalled result holds in the output register and blocks the next result.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  deq_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output deq_pkg::t_out o_out_data
);
    import deq_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic              wr_en, rd_en, load, out_free;
    logic [IW-1:0]     wr_addr, rd_addr_a, rd_addr_b;
    logic [DATA_W-1:0] wr_data, rd_data_a, rd_data_b, push_value;
    logic [CW-1:0]     count;
    logic [CW+4:0]     count_ext;
    t_res_info         info;
    t_out              n_out, r_out;
    logic              r_out_valid;

    deq_ctrl #(
        .DEPTH (DEPTH),
        .IW    (IW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_free   (out_free),
        .o_load       (load),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_en      (rd_en),
        .o_rd_addr_a  (rd_addr_a),
        .o_rd_addr_b  (rd_addr_b),
        .o_count      (count),
        .o_info       (info),
        .o_push_value (push_value)
    );

    deq_mem #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_mem (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_en     (rd_en),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b)
    );

    always_comb begin
        out_free  = !r_out_valid || !i_out_stall;
        count_ext = {5'b0, count};

        n_out.entry_count = count_ext[CNT_OUT_W-1:0];
        n_out.is_empty    = (count == '0);
        n_out.is_full     = (count == FULL_CNT);
        n_out.status      = info.status;

        if (count == '0) begin
            n_out.front_value = NONE_VALUE;
            n_out.rear_value  = NONE_VALUE;
        end else begin
            n_out.front_value = info.fwd_front ? push_value : rd_data_a;
            n_out.rear_value  = info.fwd_rear  ? push_value : rd_data_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[rtl/deq_chk.sv]
// ----------------------------------------------------------------------------
// Double-ended queue checker
// Port-level checks on sequencing and result consistency, bound to the top.
// ----------------------------------------------------------------------------
`include "double_ended_queue_defines.svh"

module deq_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input deq_pkg::t_out o_out_data
);
    import deq_pkg::*;

    logic in_acc;
    logic empty_ok;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign empty_ok = (o_out_data.front_value == NONE_VALUE)
                   && (o_out_data.rear_value == NONE_VALUE)
                   && (o_out_data.entry_count == '0);

    `DEQ_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data)), "stalled result changed")
    `DEQ_ASSERT(a_one_at_a_time, i_clk, i_rst_n, (in_acc |=> o_in_stall), "transaction taken while busy")
    `DEQ_ASSERT(a_result_source, i_clk, i_rst_n, ($rose(o_out_valid) |-> $past(in_acc, 2)), "result without transaction")
    `DEQ_ASSERT(a_empty_view, i_clk, i_rst_n, (o_out_valid && o_out_data.is_empty |-> empty_ok && !o_out_data.is_full), "empty result inconsistent")
    `DEQ_NEVER(a_status_flags, i_clk, i_rst_n, (o_out_valid && ((o_out_data.status == ST_EMPTY && !o_out_data.is_empty) || (o_out_data.status == ST_FULL && !o_out_data.is_full))), "status disagrees with flags")

endmodule

bind double_ended_queue deq_chk u_deq_chk (.*);

[tb/double_ended_queue_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives push, pop, report and unused action codes through the input
// channel, predicts the queue view after each transaction with a local copy
// of the circular store, and compares every result field by field. Both
// sides idle in random bursts except in the closing full-rate part.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
    import deq_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int DEPTH          = 16;
    localparam int RESET_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int MAX_PRINTED    = 40;

    localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
    localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

    localparam logic signed [DATA_W-1:0] MIN_VALUE = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] MAX_VALUE = {1'b0, {(DATA_W-1){1'b1}}};

    logic  i_clk       = 1'b0;
    logic  i_rst_n     = 1'b0;
    logic  i_in_valid  = 1'b0;
    logic  o_in_stall;
    t_in   i_in_data   = '0;
    logic  o_out_valid;
    logic  i_out_stall = 1'b0;
    t_out  o_out_data;

    bit    idle_on     = 1'b1;
    int    stall_left  = 0;
    int    idle_cycles = 0;
    int    mismatch_count = 0;

    logic signed [DATA_W-1:0] model_slots [DEPTH];
    int    model_head  = 0;
    int    model_count = 0;
    t_out  expected_views [$];

    double_ended_queue #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_out apply_action(input t_in item);
        t_out view;
        view.status = ST_DONE;
        case (item.action)
            ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
                if (model_count == DEPTH) begin
                    view.status = ST_FULL;
                end else if (item.action == ACT_PUSH_FRONT) begin
                    model_head = (model_head == 0) ? DEPTH - 1 : model_head - 1;
                    model_slots[model_head] = item.value;
                    model_count++;
                end else begin
                    model_slots[(model_head + model_count) % DEPTH] = item.value;
                    model_count++;
                end
            end
            ACT_POP_FRONT, ACT_POP_REAR: begin
                if (model_count == 0) begin
                    view.status = ST_EMPTY;
                end else begin
                    if (item.action == ACT_POP_FRONT)
                        model_head = (model_head + 1) % DEPTH;
                    model_count--;
                end
            end
            default: ;
        endcase
        if (model_count == 0) begin
            view.front_value = NONE_VALUE;
            view.rear_value  = NONE_VALUE;
        end else begin
            view.front_value = model_slots[model_head];
            view.rear_value  = model_slots[(model_head + model_count - 1) % DEPTH];
        end
        view.entry_count = CNT_OUT_W'(model_count);
        view.is_empty    = (model_count == 0);
        view.is_full     = (model_count == DEPTH);
        return view;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return MIN_VALUE;
            1: return MAX_VALUE;
            2: return NONE_VALUE;
            3: return '0;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [2:0] pick_action(input bit filling);
        logic [2:0] push_code;
        logic [2:0] pop_code;
        int roll;
        push_code = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
        pop_code  = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_REAR;
        roll      = $urandom_range(0, 9);
        if (roll < 7)
            return filling ? push_code : pop_code;
        if (roll < 9)
            return filling ? pop_code : push_code;
        return 3'($urandom_range(ACT_REPORT, ACT_UNUSED_HI));
    endfunction

    task automatic log_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED)
            $display("[%0t] MISMATCH %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic signed [63:0] got,
                               input logic signed [63:0] want);
        if (got !== want)
            log_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
    endtask

    task automatic send_action(input logic [2:0] code,
                               input logic signed [DATA_W-1:0] val);
        t_in item;
        int  gap;
        item.action = code;
        item.value  = val;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        expected_views.push_back(apply_action(item));
    endtask

    task automatic test_empty_queue();
        send_action(ACT_REPORT, MAX_VALUE);
        send_action(ACT_POP_FRONT, MIN_VALUE);
        send_action(ACT_POP_REAR, NONE_VALUE);
        send_action(ACT_UNUSED_LO, '0);
        send_action(ACT_UNUSED_HI, $urandom());
    endtask

    task automatic test_fill_and_overflow();
        logic signed [DATA_W-1:0] val;
        for (int i = 0; i < DEPTH; i++) begin
            case (i % 4)
                0: val = MIN_VALUE;
                1: val = MAX_VALUE;
                2: val = NONE_VALUE;
                default: val = $urandom();
            endcase
            send_action(i[0] ? ACT_PUSH_REAR : ACT_PUSH_FRONT, val);
        end
        send_action(ACT_PUSH_FRONT, $urandom());
        send_action(ACT_PUSH_REAR, $urandom());
        send_action(ACT_POP_FRONT, $urandom());
        send_action(ACT_POP_REAR, $urandom());
    endtask

    task automatic run_swings(input int items);
        bit filling;
        int segment;
        filling = 1'b0;
        segment = 0;
        for (int n = 0; n < items; n++) begin
            if (segment == 0) begin
                filling = !filling;
                segment = $urandom_range(10, 40);
            end
            segment--;
            send_action(pick_action(filling), pick_value());
        end
    endtask

    task automatic test_random_swings();
        run_swings(700);
    endtask

    task automatic test_random_uniform();
        for (int n = 0; n < 400; n++)
            send_action(3'($urandom_range(ACT_PUSH_FRONT, ACT_UNUSED_HI)), pick_value());
    endtask

    task automatic test_full_rate();
        idle_on <= 1'b0;
        run_swings(325);
    endtask

    always @(posedge i_clk) begin
        if (!idle_on) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 5);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (expected_views.size() == 0) begin
                log_mismatch("result with no transaction pending");
            end else begin
                want = expected_views.pop_front();
                check_field("front_value", 64'(o_out_data.front_value),
                            64'(want.front_value));
                check_field("rear_value", 64'(o_out_data.rear_value),
                            64'(want.rear_value));
                check_field("entry_count", 64'(o_out_data.entry_count),
                            64'(want.entry_count));
                check_field("is_empty", 64'(o_out_data.is_empty), 64'(want.is_empty));
                check_field("is_full", 64'(o_out_data.is_full), 64'(want.is_full));
                check_field("status", 64'(o_out_data.status), 64'(want.status));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("double_ended_queue verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_queue();
        test_fill_and_overflow();
        test_random_swings();
        test_random_uniform();
        test_full_rate();

        i_in_valid <= 1'b0;
        while (expected_views.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("double_ended_queue verification clean");
        end else begin
            $display("double_ended_queue verification failed");
        end
        $finish;
    end

endmodule
